FILE: sv/cdo_pkg.sv
// Package for the calendar date offset core: operand types of the shared adder,
// field widths, register indexes and the Gregorian month-length helpers. No dependencies.
`default_nettype none

package cdo_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 16;
	// signed accumulator: d + n reaches 65566, d - n reaches -65534
	localparam int ACC_W   = 18;

	localparam logic [YEAR_W-1:0] YEAR_LIMIT  = 14'd9999;
	localparam logic [YEAR_W-1:0] YEAR_CYCLE  = 14'd400;
	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1950;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2022;

	// year window register indexes
	localparam logic [1:0] REG_MIN_YEAR = 2'd0;
	localparam logic [1:0] REG_MAX_YEAR = 2'd1;

	typedef struct packed {
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
		logic             sub;
	} alu_op_t;

	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic             neg;
		logic             zero;
	} alu_res_t;

	// leap test from the year reduced modulo 400
	function automatic logic is_leap(input logic [YEAR_W-1:0] ymod);
		logic century;
		century = (ymod == 14'd0) || (ymod == 14'd100) || (ymod == 14'd200) ||
			(ymod == 14'd300);
		return ((ymod[1:0] == 2'b00) && !century) || (ymod == 14'd0);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

FILE: sv/cdo_alu.sv
// Shared add/subtract unit of the calendar date offset core.
// Depends on cdo_pkg for the operand and result types.
`default_nettype none

module cdo_alu (
	input  wire cdo_pkg::alu_op_t op,
	output cdo_pkg::alu_res_t     res
);
	import cdo_pkg::*;

	logic [ACC_W-1:0] sum;

	assign sum      = op.a + (op.sub ? ~op.b : op.b) + ACC_W'(op.sub);
	assign res.sum  = sum;
	assign res.neg  = sum[ACC_W-1];
	assign res.zero = (sum == '0);

endmodule

`default_nettype wire

FILE: sv/calendar_date_offset_core.sv
// Top level of the calendar date offset core: sequencer, year window registers
// and result registers. Depends on cdo_pkg and cdo_alu.
//
// Use: present a date (day_in, month_in, year_in), a direction (req_type,
// 0 add, 1 subtract) and day_count, and raise start. The transaction is taken
// at a rising edge with start high and busy low; busy then stays high until the
// transaction is done. The result (day_out, month_out, year_out, input_valid,
// year_overflow) is shown for exactly one cycle with done high; the receiver
// cannot stall it, and busy is already low in that cycle so a new transaction
// may be taken alongside it.
// Sequence: the year is reduced modulo 400 by one conditional subtract of
// 400 * 2^k for each k from 4 down to 0; the date is then checked and
// day_in +/- day_count formed; then the walk crosses one month per step
// and closes, all on the one shared adder. An impossible date ends after
// the check with no walk, and a year overflow also ends the walk.
// Year window: cfg_valid/cfg_ready write min_year (index 0) or max_year
// (index 1); other indexes are ignored. cfg_ready is always high; write only
// while the block is idle.
// Reset (arst_n low) returns the window to 1950..2022 and the block to idle.
`default_nettype none

module calendar_date_offset_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        req_type,
	input  wire logic [cdo_pkg::DAY_W-1:0]   day_in,
	input  wire logic [cdo_pkg::MONTH_W-1:0] month_in,
	input  wire logic [cdo_pkg::YEAR_W-1:0]  year_in,
	input  wire logic [cdo_pkg::COUNT_W-1:0] day_count,
	output logic                             done,
	output logic [cdo_pkg::DAY_W-1:0]        day_out,
	output logic [cdo_pkg::MONTH_W-1:0]      month_out,
	output logic [cdo_pkg::YEAR_W-1:0]       year_out,
	output logic                             input_valid,
	output logic                             year_overflow,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [cdo_pkg::YEAR_W-1:0]  cfg_data
);
	import cdo_pkg::*;

	localparam logic [2:0] MOD_LAST     = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_CHECK,
		ST_WALK
	} state_t;

	state_t state_q;

	logic [YEAR_W-1:0]  min_year_q, max_year_q;
	logic               sub_q;
	logic [DAY_W-1:0]   d_q;
	logic [MONTH_W-1:0] m_q;
	logic [YEAR_W-1:0]  y_q;
	logic [COUNT_W-1:0] n_q;
	logic [2:0]         k_q;
	logic [YEAR_W-1:0]  ymod_q;
	logic [MONTH_W-1:0] cm_q;
	logic [YEAR_W-1:0]  cy_q;
	logic [ACC_W-1:0]   acc_q;

	logic               done_q, valid_q, ovf_q;
	logic [DAY_W-1:0]   rd_q;
	logic [MONTH_W-1:0] rm_q;
	logic [YEAR_W-1:0]  ry_q;

	alu_op_t  alu_op;
	alu_res_t alu_res;

	logic               leap;
	logic [MONTH_W-1:0] prev_m;
	logic [DAY_W-1:0]   len_cur, len_prev, len_in;
	logic               exists, in_window;
	logic               acc_le0;

	cdo_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	assign leap     = is_leap(ymod_q);
	assign prev_m   = (cm_q == 4'd1) ? 4'd12 : cm_q - 4'd1;
	assign len_cur  = month_len(cm_q, leap);
	assign len_prev = month_len(prev_m, leap);
	// ymod_q holds year_in mod 400 once the reduction is over, for year_in up to 12799
	assign len_in   = month_len(m_q, leap);
	assign exists   = (m_q >= 4'd1) && (m_q <= 4'd12) && (y_q >= 14'd1) &&
		(y_q <= YEAR_LIMIT) && (d_q >= 5'd1) && (d_q <= len_in);
	assign in_window = (y_q >= min_year_q) && (y_q <= max_year_q);
	assign acc_le0  = acc_q[ACC_W-1] || (acc_q == '0);

	always_comb begin
		alu_op = '0;
		case (state_q)
			ST_MOD: begin
				alu_op.a   = ACC_W'(ymod_q);
				alu_op.b   = ACC_W'(YEAR_CYCLE) << (MOD_LAST - k_q);
				alu_op.sub = 1'b1;
			end
			ST_CHECK: begin
				alu_op.a   = ACC_W'(d_q);
				alu_op.b   = ACC_W'(n_q);
				alu_op.sub = sub_q;
			end
			ST_WALK: begin
				alu_op.a   = acc_q;
				alu_op.b   = sub_q ? ACC_W'(len_prev) : ACC_W'(len_cur);
				alu_op.sub = !sub_q;
			end
			default: alu_op = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RST;
			max_year_q <= MAX_YEAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_YEAR: min_year_q <= cfg_data;
				REG_MAX_YEAR: max_year_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						sub_q   <= req_type;
						d_q     <= day_in;
						m_q     <= month_in;
						y_q     <= year_in;
						n_q     <= day_count;
						ymod_q  <= year_in;
						k_q     <= 3'd0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (!alu_res.neg)
						ymod_q <= YEAR_W'(alu_res.sum);
					k_q <= k_q + 3'd1;
					if (k_q == MOD_LAST)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					valid_q <= exists && in_window;
					ovf_q   <= 1'b0;
					cm_q    <= m_q;
					cy_q    <= y_q;
					acc_q   <= alu_res.sum;
					if (exists) begin
						state_q <= ST_WALK;
					end else begin
						rd_q    <= d_q;
						rm_q    <= m_q;
						ry_q    <= y_q;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (!sub_q) begin
						// move on while the remaining day exceeds this month
						if (!alu_res.neg && !alu_res.zero) begin
							acc_q <= alu_res.sum;
							if (cm_q == 4'd12) begin
								if (cy_q == YEAR_LIMIT) begin
									ovf_q   <= 1'b1;
									rd_q    <= d_q;
									rm_q    <= m_q;
									ry_q    <= y_q;
									done_q  <= 1'b1;
									state_q <= ST_IDLE;
								end else begin
									cm_q   <= 4'd1;
									cy_q   <= cy_q + 14'd1;
									ymod_q <= (ymod_q == YEAR_CYCLE - 14'd1) ? 14'd0 :
										ymod_q + 14'd1;
								end
							end else begin
								cm_q <= cm_q + 4'd1;
							end
						end else begin
							rd_q    <= acc_q[DAY_W-1:0];
							rm_q    <= cm_q;
							ry_q    <= cy_q;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						// step back while the day is not positive
						if (acc_le0) begin
							if (cm_q == 4'd1) begin
								if (cy_q <= 14'd1) begin
									ovf_q   <= 1'b1;
									rd_q    <= d_q;
									rm_q    <= m_q;
									ry_q    <= y_q;
									done_q  <= 1'b1;
									state_q <= ST_IDLE;
								end else begin
									acc_q  <= alu_res.sum;
									cm_q   <= prev_m;
									cy_q   <= cy_q - 14'd1;
									ymod_q <= (ymod_q == 14'd0) ? YEAR_CYCLE - 14'd1 :
										ymod_q - 14'd1;
								end
							end else begin
								acc_q <= alu_res.sum;
								cm_q  <= prev_m;
							end
						end else begin
							rd_q    <= acc_q[DAY_W-1:0];
							rm_q    <= cm_q;
							ry_q    <= cy_q;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign day_out       = rd_q;
	assign month_out     = rm_q;
	assign year_out      = ry_q;
	assign input_valid   = valid_q;
	assign year_overflow = ovf_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_CHECK || state_q == ST_WALK))
		else $error("done strobe without a transaction in flight");

	a_walk_month: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (cm_q >= 4'd1 && cm_q <= 4'd12))
		else $error("walk month out of 1..12");

	a_walk_year: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (cy_q >= 14'd1 && cy_q <= YEAR_LIMIT &&
		ymod_q < YEAR_CYCLE))
		else $error("walk year or year residue out of range");

	a_ovf_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(done && year_overflow) |-> (day_out == d_q && month_out == m_q &&
		year_out == y_q))
		else $error("overflow result does not echo the input date");

endmodule

`default_nettype wire
